FILE: design/line_angle_bisector_select_assert.svh
// Assertion macros used by the line angle bisector top level.
`ifndef LINE_ANGLE_BISECTOR_SELECT_ASSERT_SVH
`define LINE_ANGLE_BISECTOR_SELECT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LAB_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define LAB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/lab_pkg.sv
// Types and constants of the line angle bisector select block.
package lab_pkg;

   // Coefficient word width, fixed by the channel payload.
   parameter int COEF_WIDTH = 32;

   typedef logic signed [COEF_WIDTH-1:0] coef_type;

   parameter coef_type COEF_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
   parameter coef_type COEF_MIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};

   // Request payload: two lines a*x + b*y + c = 0.
   typedef struct packed {
      coef_type line1_a;
      coef_type line1_b;
      coef_type line1_c;
      coef_type line2_a;
      coef_type line2_b;
      coef_type line2_c;
   } lab_req_type;

   // Response payload: the chosen bisector and flags.
   typedef struct packed {
      coef_type bis_a;
      coef_type bis_b;
      coef_type bis_c;
      logic     chose_sum;
      logic     bad_input;
   } lab_rsp_type;

   // Pipeline control handed to each line normalizer.
   typedef struct packed {
      logic load0;   // entry register takes a new request
      logic adv;     // all later stages advance
   } lab_ctl_type;

endpackage

FILE: design/line_angle_bisector_select.sv
// Line angle bisector select: top level with valid/ready channels.
//
// req_* carries a pair of lines (a, b, c each, signed Q16.16 by default).
// rsp_* returns the bisector of the two normalized lines that lies closest
// to the Y axis, saturated, with chose_sum and bad_input flags.
// One request can be accepted every cycle while the output is not stalled;
// throughput is then one per cycle. The pipeline depth is set by the
// 32-stage square root and the restoring dividers, one digit per stage,
// that run over COEF_WIDTH + FRAC_BITS + 30 numerator bits when
// FRAC_BITS + 30 >= COEF_WIDTH - 1.
// When rsp_ready is low with a response waiting, the whole pipeline holds;
// the entry register still takes one more request if it is empty.
// No request is lost or repeated during a stall.
// Reset (synchronous, active high) clears all valid bits; data registers
// are not reset. The block has no configuration and no state across
// requests.
`include "line_angle_bisector_select_assert.svh"

module line_angle_bisector_select import lab_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  lab_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output lab_rsp_type rsp_data
);

   localparam int W     = COEF_WIDTH;
   localparam int EOFF  = (W - 1 > FRAC_BITS + 30) ? W - 1 - FRAC_BITS - 30 : 0;
   localparam int NW    = W + FRAC_BITS + 30 + EOFF;
   localparam int LN    = NW + 39;
   localparam int AW    = FRAC_BITS + 2;
   localparam int CW    = W + 1;
   localparam int BW    = W + FRAC_BITS + 4;

   // Magnitude of an a/b sum or difference, which stays within 2^(FRAC_BITS+1).
   function automatic logic [AW-1:0] mag_ab(input logic signed [AW:0] x);
      logic [AW:0] t;
      t = x[AW] ? -x : x;
      return t[AW-1:0];
   endfunction

   function automatic coef_type sat_ab(input logic signed [AW:0] x);
      logic signed [BW-1:0] w;
      w = BW'(x);
      if (w[BW-1:W-1] != {(BW-W+1){w[BW-1]}}) begin
         return w[BW-1] ? COEF_MIN : COEF_MAX;
      end
      return w[W-1:0];
   endfunction

   function automatic coef_type sat_c(input logic signed [CW:0] x);
      logic signed [BW-1:0] w;
      w = BW'(x);
      if (w[BW-1:W-1] != {(BW-W+1){w[BW-1]}}) begin
         return w[BW-1] ? COEF_MIN : COEF_MAX;
      end
      return w[W-1:0];
   endfunction

   lab_ctl_type ctl;
   logic        pipe_adv;
   logic [LN+2:0] vld_ff;
   logic        rsp_valid_ff;
   lab_rsp_type rsp_ff, rsp_in;

   logic signed [AW-1:0] n1a, n1b, n2a, n2b;
   logic signed [CW-1:0] n1c, n2c;
   logic                 bad1, bad2;

   logic signed [AW:0]   da_ff, db_ff, sa_ff, sb_ff;
   logic signed [CW:0]   dc_ff, sc_ff;
   logic                 bad0_ff;

   logic signed [AW:0]   da1_ff, db1_ff, sa1_ff, sb1_ff;
   logic signed [CW:0]   dc1_ff, sc1_ff;
   logic                 bad1_ff, ddeg_ff, sdeg_ff;
   logic [2*AW-1:0]      pd_ff, ps_ff;
   logic                 pick_sum;

   // Global advance whenever the output register is free or being drained.
   assign pipe_adv  = !rsp_valid_ff || rsp_ready;
   assign ctl.adv   = pipe_adv;
   assign ctl.load0 = pipe_adv || !vld_ff[0];
   assign req_ready = ctl.load0;

   lab_norm #(.FRAC_BITS(FRAC_BITS)) u_norm1 (
      .clock  (clock),
      .ctl    (ctl),
      .line_a (req_data.line1_a),
      .line_b (req_data.line1_b),
      .line_c (req_data.line1_c),
      .norm_a (n1a),
      .norm_b (n1b),
      .norm_c (n1c),
      .degen  (bad1)
   );

   lab_norm #(.FRAC_BITS(FRAC_BITS)) u_norm2 (
      .clock  (clock),
      .ctl    (ctl),
      .line_a (req_data.line2_a),
      .line_b (req_data.line2_b),
      .line_c (req_data.line2_c),
      .norm_a (n2a),
      .norm_b (n2b),
      .norm_c (n2c),
      .degen  (bad2)
   );

   // Valid bits that travel alongside the data stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctl.load0) vld_ff[0] <= req_valid;
         if (pipe_adv) begin
            vld_ff[LN+2:1] <= vld_ff[LN+1:0];
            rsp_valid_ff   <= vld_ff[LN+2];
         end
      end
   end

   // Difference and sum bisectors, then cross products.
   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         da_ff   <= (AW+1)'(n1a) - (AW+1)'(n2a);
         db_ff   <= (AW+1)'(n1b) - (AW+1)'(n2b);
         dc_ff   <= (CW+1)'(n1c) - (CW+1)'(n2c);
         sa_ff   <= (AW+1)'(n1a) + (AW+1)'(n2a);
         sb_ff   <= (AW+1)'(n1b) + (AW+1)'(n2b);
         sc_ff   <= (CW+1)'(n1c) + (CW+1)'(n2c);
         bad0_ff <= bad1 | bad2;

         da1_ff  <= da_ff;
         db1_ff  <= db_ff;
         dc1_ff  <= dc_ff;
         sa1_ff  <= sa_ff;
         sb1_ff  <= sb_ff;
         sc1_ff  <= sc_ff;
         bad1_ff <= bad0_ff;
         ddeg_ff <= (da_ff == '0) && (db_ff == '0);
         sdeg_ff <= (sa_ff == '0) && (sb_ff == '0);
         pd_ff   <= (2*AW)'(mag_ab(da_ff)) * (2*AW)'(mag_ab(sb_ff));
         ps_ff   <= (2*AW)'(mag_ab(sa_ff)) * (2*AW)'(mag_ab(db_ff));

         rsp_ff  <= rsp_in;
      end
   end

   // Selection: a degenerate bisector loses, a tie keeps the difference.
   always_comb begin
      if (ddeg_ff && !sdeg_ff) begin
         pick_sum = 1'b1;
      end else if (sdeg_ff) begin
         pick_sum = 1'b0;
      end else begin
         pick_sum = !(pd_ff >= ps_ff);
      end
      rsp_in.bis_a     = sat_ab(pick_sum ? sa1_ff : da1_ff);
      rsp_in.bis_b     = sat_ab(pick_sum ? sb1_ff : db1_ff);
      rsp_in.bis_c     = sat_c(pick_sum ? sc1_ff : dc1_ff);
      rsp_in.chose_sum = pick_sum;
      rsp_in.bad_input = bad1_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `LAB_ASSERT_IMPLY(a_ready_when_out_free, clock, reset, !rsp_valid_ff, req_ready, "request refused with a free output register")
   `LAB_ASSERT_IMPLY(a_sum_not_degenerate, clock, reset, rsp_valid_ff && rsp_ff.chose_sum, (rsp_ff.bis_a != '0) || (rsp_ff.bis_b != '0), "degenerate sum bisector chosen")
   `LAB_ASSERT_NEXT(a_stall_holds_pipe, clock, reset, !pipe_adv, vld_ff[LN+2:1] == $past(vld_ff[LN+2:1]), "pipeline moved during a stall")

endmodule

FILE: design/lab_norm.sv
// Pipelined line normalizer: scales (a, b, c) by 1/sqrt(a*a + b*b).
module lab_norm import lab_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  lab_ctl_type                   ctl,
   input  coef_type                      line_a,
   input  coef_type                      line_b,
   input  coef_type                      line_c,
   output logic signed [FRAC_BITS+1:0]   norm_a,
   output logic signed [FRAC_BITS+1:0]   norm_b,
   output logic signed [COEF_WIDTH:0]    norm_c,
   output logic                          degen
);

   localparam int W     = COEF_WIDTH;
   localparam int EOFF  = (W - 1 > FRAC_BITS + 30) ? W - 1 - FRAC_BITS - 30 : 0;
   localparam int SHMAX = FRAC_BITS + 30 + EOFF;
   localparam int NW    = W + SHMAX;
   localparam int QW    = (W + EOFF > FRAC_BITS + 1) ? W + EOFF : FRAC_BITS + 1;
   localparam int PW    = $clog2(W);
   localparam int SQN   = 32;
   localparam int AW    = FRAC_BITS + 2;

   typedef struct packed {
      logic          na;
      logic          nb;
      logic          nc;
      logic          zero;
      logic [W-1:0]  ma;
      logic [W-1:0]  mb;
      logic [W-1:0]  mc;
      logic [PW-1:0] p;
   } fr_type;

   typedef struct packed {
      logic          na;
      logic          nb;
      logic          nc;
      logic          zero;
      logic [30:0]   ua;
      logic [30:0]   ub;
      logic [NW-1:0] numc;
   } sh_type;

   typedef struct packed {
      logic          na;
      logic          nb;
      logic          nc;
      logic          zero;
      logic [61:0]   sqa;
      logic [61:0]   sqb;
      logic [NW-1:0] numa;
      logic [NW-1:0] numb;
      logic [NW-1:0] numc;
   } mul_type;

   typedef struct packed {
      logic          na;
      logic          nb;
      logic          nc;
      logic          zero;
      logic [63:0]   n;
      logic [63:0]   r;
      logic [NW-1:0] numa;
      logic [NW-1:0] numb;
      logic [NW-1:0] numc;
   } sr_type;

   typedef struct packed {
      logic          na;
      logic          nb;
      logic          nc;
      logic          zero;
      logic          sat;
      logic [31:0]   k;
      logic [NW-1:0] numa;
      logic [NW-1:0] numb;
      logic [NW-1:0] numc;
      logic [31:0]   rema;
      logic [31:0]   remb;
      logic [31:0]   remc;
      logic [QW-1:0] qa;
      logic [QW-1:0] qb;
      logic [QW-1:0] qc;
   } dv_type;

   // One square root digit: compare and subtract against r + bit.
   function automatic sr_type sq_step(input sr_type s, input logic [63:0] bitv);
      sr_type      o;
      logic [63:0] t;
      o = s;
      t = s.r + bitv;
      if (s.n >= t) begin
         o.n = s.n - t;
         o.r = (s.r >> 1) + bitv;
      end else begin
         o.r = s.r >> 1;
      end
      return o;
   endfunction

   // One restoring division digit: returns {quotient bit, new remainder}.
   function automatic logic [32:0] dstep(input logic [31:0] rem, input logic nbit,
                                         input logic [31:0] k);
      logic [32:0] t;
      t = {rem, nbit};
      if (t >= {1'b0, k}) begin
         return {1'b1, 32'(t - {1'b0, k})};
      end else begin
         return {1'b0, t[31:0]};
      end
   endfunction

   // One digit for all three dividers.
   function automatic dv_type dv_step(input dv_type d);
      dv_type      o;
      logic [32:0] ra;
      logic [32:0] rb;
      logic [32:0] rc;
      o  = d;
      ra = dstep(d.rema, d.numa[NW-1], d.k);
      rb = dstep(d.remb, d.numb[NW-1], d.k);
      rc = dstep(d.remc, d.numc[NW-1], d.k);
      o.rema = ra[31:0];
      o.remb = rb[31:0];
      o.remc = rc[31:0];
      o.qa   = {d.qa[QW-2:0], ra[32]};
      o.qb   = {d.qb[QW-2:0], rb[32]};
      o.qc   = {d.qc[QW-2:0], rc[32]};
      o.sat  = d.sat | d.qc[QW-1];
      o.numa = d.numa << 1;
      o.numb = d.numb << 1;
      o.numc = d.numc << 1;
      return o;
   endfunction

   coef_type raw_a_ff, raw_b_ff, raw_c_ff;
   fr_type   f1_ff, f1_in, f2_ff, f2_in;
   sh_type   sh_ff, sh_in;
   mul_type  mul_ff, mul_in;
   sr_type   sr_ff [0:SQN];
   sr_type   sr_in [0:SQN];
   dv_type   dv_ff [0:NW];
   dv_type   dv_in [0:NW];

   logic [W-1:0]  mx;
   logic [W+29:0] ua_wide, ub_wide;
   logic [QW-1:0] qc_sh;
   logic [W-1:0]  cmag;
   logic signed [AW-1:0] norm_a_in, norm_b_in;
   logic signed [W:0]    norm_c_in;

   // Entry register.
   always_ff @(posedge clock) begin
      if (ctl.load0) begin
         raw_a_ff <= line_a;
         raw_b_ff <= line_b;
         raw_c_ff <= line_c;
      end
   end

   // Signs and magnitudes.
   always_comb begin
      f1_in      = '0;
      f1_in.na   = raw_a_ff[W-1];
      f1_in.nb   = raw_b_ff[W-1];
      f1_in.nc   = raw_c_ff[W-1];
      f1_in.ma   = raw_a_ff[W-1] ? W'(-raw_a_ff) : W'(raw_a_ff);
      f1_in.mb   = raw_b_ff[W-1] ? W'(-raw_b_ff) : W'(raw_b_ff);
      f1_in.mc   = raw_c_ff[W-1] ? W'(-raw_c_ff) : W'(raw_c_ff);
      f1_in.zero = (raw_a_ff == '0) && (raw_b_ff == '0);
   end

   // Top set bit of max(|a|, |b|).
   always_comb begin
      f2_in = f1_ff;
      mx    = (f1_ff.ma > f1_ff.mb) ? f1_ff.ma : f1_ff.mb;
      f2_in.p = '0;
      for (int i = 0; i < W; i++) begin
         if (mx[i]) f2_in.p = PW'(i);
      end
   end

   // Normalizing shifts: top bit of (a, b) lands at bit 30.
   always_comb begin
      ua_wide    = {f2_ff.ma, 30'b0} >> f2_ff.p;
      ub_wide    = {f2_ff.mb, 30'b0} >> f2_ff.p;
      sh_in.na   = f2_ff.na;
      sh_in.nb   = f2_ff.nb;
      sh_in.nc   = f2_ff.nc;
      sh_in.zero = f2_ff.zero;
      sh_in.ua   = ua_wide[30:0];
      sh_in.ub   = ub_wide[30:0];
      sh_in.numc = {f2_ff.mc, {SHMAX{1'b0}}} >> f2_ff.p;
   end

   // Squares and divider numerators.
   always_comb begin
      mul_in.na   = sh_ff.na;
      mul_in.nb   = sh_ff.nb;
      mul_in.nc   = sh_ff.nc;
      mul_in.zero = sh_ff.zero;
      mul_in.sqa  = 62'(sh_ff.ua) * 62'(sh_ff.ua);
      mul_in.sqb  = 62'(sh_ff.ub) * 62'(sh_ff.ub);
      mul_in.numa = NW'({sh_ff.ua, {FRAC_BITS{1'b0}}});
      mul_in.numb = NW'({sh_ff.ub, {FRAC_BITS{1'b0}}});
      mul_in.numc = sh_ff.numc;
   end

   // Sum of squares, then one square root digit per stage.
   always_comb begin
      sr_in[0].na   = mul_ff.na;
      sr_in[0].nb   = mul_ff.nb;
      sr_in[0].nc   = mul_ff.nc;
      sr_in[0].zero = mul_ff.zero;
      sr_in[0].n    = 64'(mul_ff.sqa) + 64'(mul_ff.sqb);
      sr_in[0].r    = '0;
      sr_in[0].numa = mul_ff.numa;
      sr_in[0].numb = mul_ff.numb;
      sr_in[0].numc = mul_ff.numc;
      for (int j = 1; j <= SQN; j++) begin
         sr_in[j] = sq_step(sr_ff[j-1], 64'd1 << (64 - 2 * j));
      end
   end

   // Divider setup, then one quotient digit per stage.
   always_comb begin
      dv_in[0].na   = sr_ff[SQN].na;
      dv_in[0].nb   = sr_ff[SQN].nb;
      dv_in[0].nc   = sr_ff[SQN].nc;
      dv_in[0].zero = sr_ff[SQN].zero;
      dv_in[0].sat  = 1'b0;
      dv_in[0].k    = sr_ff[SQN].r[31:0];
      dv_in[0].numa = sr_ff[SQN].numa;
      dv_in[0].numb = sr_ff[SQN].numb;
      dv_in[0].numc = sr_ff[SQN].numc;
      dv_in[0].rema = '0;
      dv_in[0].remb = '0;
      dv_in[0].remc = '0;
      dv_in[0].qa   = '0;
      dv_in[0].qb   = '0;
      dv_in[0].qc   = '0;
      for (int j = 1; j <= NW; j++) begin
         dv_in[j] = dv_step(dv_ff[j-1]);
      end
   end

   // Cap c, apply signs, zero out a degenerate line.
   always_comb begin
      qc_sh = dv_ff[NW].qc >> EOFF;
      if (dv_ff[NW].sat || (qc_sh > (QW'(1) << (W - 1)))) begin
         cmag = W'(1) << (W - 1);
      end else begin
         cmag = qc_sh[W-1:0];
      end
      norm_a_in = dv_ff[NW].na ? -AW'({1'b0, dv_ff[NW].qa[FRAC_BITS:0]})
                               :  AW'({1'b0, dv_ff[NW].qa[FRAC_BITS:0]});
      norm_b_in = dv_ff[NW].nb ? -AW'({1'b0, dv_ff[NW].qb[FRAC_BITS:0]})
                               :  AW'({1'b0, dv_ff[NW].qb[FRAC_BITS:0]});
      norm_c_in = dv_ff[NW].nc ? -(W+1)'({1'b0, cmag}) : (W+1)'({1'b0, cmag});
      if (dv_ff[NW].zero) begin
         norm_a_in = '0;
         norm_b_in = '0;
         norm_c_in = '0;
      end
   end

   // Stage registers behind the entry register.
   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         f1_ff  <= f1_in;
         f2_ff  <= f2_in;
         sh_ff  <= sh_in;
         mul_ff <= mul_in;
         for (int j = 0; j <= SQN; j++) sr_ff[j] <= sr_in[j];
         for (int j = 0; j <= NW; j++) dv_ff[j] <= dv_in[j];
         norm_a <= norm_a_in;
         norm_b <= norm_b_in;
         norm_c <= norm_c_in;
         degen  <= dv_ff[NW].zero;
      end
   end

endmodule
